// ----- sv/pcm_format_convert_with_gain_macros.svh -----
// ----------------------------------------------------------------------------
// PCM format converter assertion macros
// Shared assertion forms for the converter; all are clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PCM_FORMAT_CONVERT_WITH_GAIN_MACROS_SVH
`define PCM_FORMAT_CONVERT_WITH_GAIN_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PFC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcm converter: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define PFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcm converter: next-cycle check failed");

`endif

// ----- sv/pcmfc_pkg.sv -----
// ----------------------------------------------------------------------------
// PCM format converter package
// Format codes, widths and reset values shared by the converter.
// ----------------------------------------------------------------------------
package pcmfc_pkg;

    localparam int RAW_W  = 32;
    localparam int PCM_W  = 16;
    localparam int FMT_W  = 2;
    localparam int VOL_W  = 9;

    localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_F32 = 2'd2;

    localparam logic [VOL_W-1:0] VOL_RESET = 9'd179;
    localparam logic [VOL_W-1:0] VOL_UNITY = 9'd256;

    // register indexes on the configuration port
    localparam logic REG_FORMAT = 1'b0;
    localparam logic REG_VOLUME = 1'b1;

    // float scale factor 32767 as an integer multiplier
    localparam logic [14:0] F32_SCALE = 15'd32767;

endpackage

// ----- sv/pcm_format_convert_with_gain.sv -----
// Data path: an input transfer loads the input register, then the sample moves
// through the product, conversion and output registers before the result is valid.
// Throughput: one sample per cycle; the whole pipeline stalls only while a
// result is held by out_ready low.
// Reset: asynchronous active-low rst_n clears all valid flags and sets
// fmt_reg to signed 16-bit and vol_reg to 179.
// ----------------------------------------------------------------------------
// PCM format converter with gain
// Reads a raw word as unsigned 8-bit, signed 16-bit or float32, converts it
// to signed 16-bit PCM and applies a Q8 volume with arithmetic shift.
// ----------------------------------------------------------------------------
`include "pcm_format_convert_with_gain_macros.svh"

module pcm_format_convert_with_gain (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] raw_sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [15:0] pcm_sample
);

    // configuration registers
    logic [1:0] fmt_reg;
    logic [8:0] vol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= pcmfc_pkg::FMT_S16;
            vol_reg <= pcmfc_pkg::VOL_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                pcmfc_pkg::REG_FORMAT: fmt_reg <= cfg_wdata[1:0];
                pcmfc_pkg::REG_VOLUME: vol_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline advance: whole pipe moves unless a result is held
    logic adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // stage 0: input register
    logic        in_v_reg;
    logic [31:0] raw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (adv)
            in_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
            raw_reg <= raw_sample;
    end

    // stage 1: float mantissa times 32767
    logic [23:0] mant;
    logic [38:0] prod_next;
    assign mant      = {(raw_reg[30:23] != 8'd0), raw_reg[22:0]};
    assign prod_next = 39'(mant) * 39'(pcmfc_pkg::F32_SCALE);

    logic        prod_v_reg;
    logic [38:0] prod_reg;
    logic [31:0] praw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_v_reg <= 1'b0;
        else if (adv)
            prod_v_reg <= in_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_v_reg)
        begin
            prod_reg <= prod_next;
            praw_reg <= raw_reg;
        end
    end

    // stage 2: round product to single precision, truncate, clamp, select
    logic [7:0]  exp_b;
    logic        f_sign;
    logic        f_nan;
    logic        f_sat;
    logic        rup15;
    logic        rup14;
    logic [39:0] vr;
    logic [7:0]  sh;
    logic [39:0] mag_full;
    logic [17:0] mag;
    logic [15:0] f_mag;
    logic signed [15:0] f_res;
    logic signed [15:0] conv_next;

    always_comb
    begin
        exp_b  = praw_reg[30:23];
        f_sign = praw_reg[31];
        f_nan  = (exp_b == 8'hFF) && (praw_reg[22:0] != 23'd0);
        f_sat  = (exp_b > 8'd127);
        // round to nearest even on 24 significant bits
        rup15 = (prod_reg[14:0] > 15'h4000)
              || ((prod_reg[14:0] == 15'h4000) && prod_reg[15]);
        rup14 = (prod_reg[13:0] > 14'h2000)
              || ((prod_reg[13:0] == 14'h2000) && prod_reg[14]);
        if (prod_reg[38])
            vr = {1'b0, prod_reg[38:15], 15'd0} + (rup15 ? 40'h8000 : 40'd0);
        else
            vr = {1'b0, prod_reg[38:14], 14'd0} + (rup14 ? 40'h4000 : 40'd0);
        // value = vr * 2^(E-150); truncation toward zero on magnitude
        sh = 8'd150 - exp_b;
        if (sh >= 8'd40)
            mag_full = 40'd0;
        else
            mag_full = vr >> sh[5:0];
        mag = mag_full[17:0];
        if (f_sign)
        begin
            if (f_sat || mag >= 18'd32768)
                f_mag = 16'h8000;
            else
                f_mag = mag[15:0];
            f_res = -$signed(f_mag);
        end
        else
        begin
            if (f_sat || mag >= 18'd32767)
                f_mag = 16'h7FFF;
            else
                f_mag = mag[15:0];
            f_res = $signed(f_mag);
        end
        if (f_nan)
            f_res = 16'sd0;

        case (fmt_reg)
            pcmfc_pkg::FMT_U8:  conv_next = {~praw_reg[7], praw_reg[6:0], 8'd0};
            pcmfc_pkg::FMT_F32: conv_next = f_res;
            default:            conv_next = praw_reg[15:0];
        endcase
    end

    logic               conv_v_reg;
    logic signed [15:0] conv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            conv_v_reg <= 1'b0;
        else if (adv)
            conv_v_reg <= prod_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && prod_v_reg)
            conv_reg <= conv_next;
    end

    // stage 3: Q8 gain, floor by arithmetic shift
    logic [8:0]         vol_eff;
    logic signed [25:0] gprod;
    logic signed [15:0] out_next;

    always_comb
    begin
        vol_eff  = (vol_reg > pcmfc_pkg::VOL_UNITY) ? pcmfc_pkg::VOL_UNITY : vol_reg;
        gprod    = 26'(conv_reg) * $signed({17'd0, vol_eff});
        out_next = 16'(gprod >>> 8);
    end

    logic               out_v_reg;
    logic signed [15:0] out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (adv)
            out_v_reg <= conv_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && conv_v_reg)
            out_reg <= out_next;
    end

    assign out_valid  = out_v_reg;
    assign pcm_sample = out_reg;

    // assertions
    `PFC_ASSERT_NEXT(a_held_stable, out_valid && !out_ready, out_valid && $stable(pcm_sample))
    `PFC_ASSERT_NEXT(a_accept_fills, in_valid && in_ready, in_v_reg)
    `PFC_ASSERT_NEXT(a_conv_to_out, conv_v_reg && adv, out_valid)
    `PFC_ASSERT_SAME(a_held_stalls, out_valid && !out_ready, !in_ready)

endmodule

// ----- bench/pcm_format_convert_with_gain_checker.sv -----
// ----------------------------------------------------------------------------
// PCM format converter checker
// Watches the configuration port and both sample channels, predicts each
// converted and gain-scaled sample and compares it with the block's output.
// ----------------------------------------------------------------------------
module pcm_format_convert_with_gain_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [8:0]         cfg_wdata,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [31:0]        raw_sample,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [15:0] pcm_sample,
    output int                 fail_count,
    output int                 pending
);

    logic [pcmfc_pkg::FMT_W-1:0] fmt_q;
    logic [pcmfc_pkg::VOL_W-1:0] vol_q;
    logic signed [15:0]          pcm_due[$];

    // float32 times 32767, rounded to single precision, clamped, truncated
    function automatic logic signed [15:0] float_to_pcm(logic [31:0] w);
        logic [7:0]  e;
        logic [63:0] p;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] ip;
        int          len;
        int          sh;
        int          k;
        e = w[30:23];
        if (e == 8'hFF && w[22:0] != 0)
            return 16'sd0;
        p = (e == 0) ? {41'd0, w[22:0]} : {40'd0, 1'b1, w[22:0]};
        k = (e == 0) ? -149 : int'(e) - 150;
        p = p * 64'd32767;
        len = 0;
        for (int i = 0; i < 64; i++)
            if (p[i])
                len = i + 1;
        // round to nearest even on 24 significant bits
        if (len > 24)
        begin
            sh   = len - 24;
            rem  = p & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            p    = p >> sh;
            if (rem > half || (rem == half && p[0]))
                p = p + 64'd1;
            p = p << sh;
        end
        if (p == 0)
            ip = 0;
        else if (k >= 0)
            ip = (k >= 20) ? 64'd65535 : (p << k);
        else if (-k >= 64)
            ip = 0;
        else
            ip = p >> (-k);
        if (!w[31])
            return (ip > 64'd32767) ? 16'sd32767 : 16'(ip);
        return (ip >= 64'd32768) ? 16'sh8000 : -16'(ip);
    endfunction

    // format decode followed by Q8 gain with floor shift
    function automatic logic signed [15:0] pcm_expected(logic [31:0] raw);
        logic signed [31:0] s;
        logic signed [31:0] prod;
        int                 vol;
        case (fmt_q)
            pcmfc_pkg::FMT_U8:  s = (int'(raw[7:0]) - 128) * 256;
            pcmfc_pkg::FMT_F32: s = float_to_pcm(raw);
            default:            s = $signed(raw[15:0]);
        endcase
        vol  = (vol_q > pcmfc_pkg::VOL_UNITY) ? int'(pcmfc_pkg::VOL_UNITY) : int'(vol_q);
        prod = s * vol;
        return 16'(prod >>> 8);
    endfunction

    assign pending = pcm_due.size();

    // track registers, queue predictions and compare each result transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_q = pcmfc_pkg::FMT_S16;
            vol_q = pcmfc_pkg::VOL_RESET;
            pcm_due.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pcm_due.size() == 0)
                begin
                    $error("unexpected transfer: pcm_sample actual %0d", pcm_sample);
                    fail_count++;
                end
                else if (pcm_sample !== pcm_due[0])
                begin
                    $error("pcm_sample mismatch: expected %0d actual %0d",
                           pcm_due[0], pcm_sample);
                    fail_count++;
                    void'(pcm_due.pop_front());
                end
                else
                    void'(pcm_due.pop_front());
            end
            if (in_valid && in_ready)
                pcm_due.push_back(pcm_expected(raw_sample));
            if (cfg_wr_en)
            begin
                if (cfg_index == pcmfc_pkg::REG_FORMAT)
                    fmt_q = cfg_wdata[pcmfc_pkg::FMT_W-1:0];
                else
                    vol_q = cfg_wdata;
            end
        end
    end

endmodule

// ----- bench/pcm_format_convert_with_gain_test.sv -----
// ----------------------------------------------------------------------------
// PCM format converter testbench
// Runs the converter through a series of format and gain settings, each with
// directed corner samples and random traffic, under random idling on both
// channels and one long output hold-off.
// ----------------------------------------------------------------------------
module pcm_format_convert_with_gain_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT     = 1000;
    localparam int HOLD_LEN    = 300;
    localparam int CALM_FROM   = 1500;
    localparam int CALM_TO     = 2000;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic               cfg_index;
    logic [8:0]         cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic [31:0]        raw_sample;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] pcm_sample;
    int                 fail_count;
    int                 pending;
    int                 cycles;
    int                 hold_left;
    int                 sent;

    pcm_format_convert_with_gain u_dut (.*);

    pcm_format_convert_with_gain_checker u_chk (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("pcm_format_convert_with_gain verification failed");
            $finish;
        end
    end

    // receiver: random stalls, a calm window and one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else if (cycles == HOLD_AT)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_LEN;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (cycles > CALM_FROM && cycles < CALM_TO)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 24);
    end

    task automatic send_sample(input logic [31:0] raw);
        in_valid   <= 1'b1;
        raw_sample <= raw;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
        // idle between transfers, except inside the calm window
        if (!(sent > 700 && sent < 1000) && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_regs(input logic [8:0] fmt, input logic [8:0] vol);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= pcmfc_pkg::REG_FORMAT;
        cfg_wdata <= fmt;
        @(posedge clk);
        cfg_index <= pcmfc_pkg::REG_VOLUME;
        cfg_wdata <= vol;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] random_sample;
        logic [31:0] w;
        w = $urandom;
        // half of the samples are floats of audio-like magnitude
        if ($urandom_range(1))
            w[30:23] = 8'($urandom_range(100, 145));
        return w;
    endfunction

    task automatic run_phase(input int count);
        logic [31:0] corner[$];
        corner = '{32'h0, 32'hFFFF_FFFF, 32'h80, 32'h7F, 32'hFF, 32'h8000, 32'h7FFF,
                   32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000, 32'hFF80_0000,
                   32'h7FC0_0000, 32'h0000_0001, 32'h3F7F_FFFF, 32'h4700_0000,
                   32'h8000_0000, 32'hBF7F_FFFF, 32'hFFFF_FF00, 32'h1234_8001};
        foreach (corner[i])
            send_sample(corner[i]);
        repeat (count)
            send_sample(random_sample());
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = pcmfc_pkg::REG_FORMAT;
        cfg_wdata  = '0;
        in_valid   = 1'b0;
        raw_sample = '0;
        cycles     = 0;
        sent       = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings first, then a sweep of formats and gains
        run_phase(100);
        write_regs(9'(pcmfc_pkg::FMT_U8), 9'd256);
        run_phase(100);
        write_regs(9'(pcmfc_pkg::FMT_F32), 9'd256);
        run_phase(300);
        write_regs(9'(pcmfc_pkg::FMT_S16), 9'd0);
        run_phase(80);
        write_regs(9'h1FF, 9'h1FF);
        run_phase(100);
        write_regs(9'h1FC, 9'd1);
        run_phase(100);
        write_regs(9'(pcmfc_pkg::FMT_F32), 9'd179);
        run_phase(250);
        write_regs(9'(pcmfc_pkg::FMT_F32), 9'd300);
        run_phase(100);
        write_regs(9'(pcmfc_pkg::FMT_U8), 9'd0);
        run_phase(60);
        write_regs(9'h1FD, 9'd255);
        run_phase(100);
        write_regs(9'($urandom_range(2)), 9'($urandom));
        run_phase(150);

        drain();
        if (fail_count == 0)
            $display("pcm_format_convert_with_gain verification clean");
        else
            $display("pcm_format_convert_with_gain verification failed");
        $finish;
    end

endmodule
